// ===== src/dges_pkg.sv =====
// Package with shared constants, operation codes and types for the graph edge store.
package dges_pkg;
    localparam int MAX_VERTICES_DEF = 16;
    localparam int COST_WIDTH_DEF = 32;
    localparam int OP_WIDTH = 3;
    localparam int SLOT_WIDTH = 4;
    localparam int IO_COST_WIDTH = 32;
    localparam int DEG_WIDTH = 5;
    localparam int EDGES_WIDTH = 9;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD_VERTEX = 3'd0,
        OP_DEL_VERTEX = 3'd1,
        OP_ADD_EDGE   = 3'd2,
        OP_DEL_EDGE   = 3'd3,
        OP_SET_COST   = 3'd4,
        OP_LOOKUP     = 3'd5
    } op_t;

    typedef struct packed {
        logic [OP_WIDTH-1:0]      operation;
        logic [SLOT_WIDTH-1:0]    src_vertex;
        logic [SLOT_WIDTH-1:0]    dst_vertex;
        logic signed [IO_COST_WIDTH-1:0] edge_cost;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [IO_COST_WIDTH-1:0] cost_out;
        logic                     src_present;
        logic [DEG_WIDTH-1:0]     src_in_degree;
        logic [DEG_WIDTH-1:0]     src_out_degree;
        logic [DEG_WIDTH-1:0]     total_vertices;
        logic [EDGES_WIDTH-1:0]   total_edges;
    } rsp_t;
endpackage

// ===== src/dges_stream_if.sv =====
// Valid-ready channel interface carrying one payload.
interface dges_stream_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/directed_graph_edge_store_core.sv =====
// Top level of the directed weighted graph edge store.
// Edge operations, vertex adds, removals of absent vertices and unknown codes pass through issue,
// memory read, execute and write back, and output; a new input is taken only once the result is registered.
// Removing a present vertex walks its row and column one entry a cycle; a held result stalls input.
// After reset the graph is empty; a clearing pass wipes all 4**clog2(MAX_VERTICES) entries of the edge memory.
module directed_graph_edge_store_core #(
    parameter int MAX_VERTICES = dges_pkg::MAX_VERTICES_DEF,
    parameter int COST_WIDTH = dges_pkg::COST_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    dges_stream_if.sink   req,
    dges_stream_if.source rsp
);
    import dges_pkg::*;

    localparam int NV = MAX_VERTICES;
    localparam int VW = $clog2(NV);
    localparam int EW = 2 * VW;
    localparam int NE = 1 << EW;
    localparam int MW = COST_WIDTH + 1;
    localparam int VCW = $clog2(NV + 1);
    localparam int ECW = $clog2(NV * NV + 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_EXEC  = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    req_t   cur_reg;
    logic   [NV-1:0] present_reg;
    logic   [VCW-1:0] in_deg_reg [NV];
    logic   [VCW-1:0] out_deg_reg [NV];
    logic   [VCW-1:0] vcount_reg;
    logic   [ECW-1:0] ecount_reg;
    logic   [EW-1:0]  clr_reg;
    logic   [VW-1:0]  sj_reg, pj_reg;
    logic   scol_reg, pcol_reg;
    logic   issue_reg, pend_reg;
    logic   ok_reg;
    logic   [COST_WIDTH-1:0] cost_reg;
    logic   out_valid_reg;
    rsp_t   out_reg;

    logic x_ok, y_ok, ends, edge_set, hit, rsp_free, accept;
    logic [VW-1:0] xs, ys;
    logic [EW-1:0] eaddr, sweep_raddr, sweep_waddr;
    logic ram_we;
    logic [EW-1:0] ram_waddr, ram_raddr;
    logic [MW-1:0] ram_wdata, ram_rdata;
    logic [COST_WIDTH-1:0] cost_st, cost_old, exec_cost;
    logic exec_ok;

    assign x_ok = 32'(cur_reg.src_vertex) < NV;
    assign y_ok = 32'(cur_reg.dst_vertex) < NV;
    assign xs = VW'(cur_reg.src_vertex);
    assign ys = VW'(cur_reg.dst_vertex);
    assign ends = x_ok && y_ok && present_reg[xs] && present_reg[ys];
    assign eaddr = {xs, ys};
    assign sweep_raddr = scol_reg ? {sj_reg, xs} : {xs, sj_reg};
    assign sweep_waddr = pcol_reg ? {pj_reg, xs} : {xs, pj_reg};

    assign cost_st = COST_WIDTH'({{(64-IO_COST_WIDTH){cur_reg.edge_cost[IO_COST_WIDTH-1]}},
                                  cur_reg.edge_cost});
    assign edge_set = ram_rdata[COST_WIDTH];
    assign cost_old = ram_rdata[COST_WIDTH-1:0];
    assign hit = ends && edge_set;

    assign ram_raddr = (state_reg == ST_SWEEP) ? sweep_raddr : eaddr;

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = eaddr;
        ram_wdata = {1'b1, cost_st};
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_EXEC:
            begin
                ram_we = ((cur_reg.operation == OP_ADD_EDGE) && ends && !edge_set) ||
                         ((cur_reg.operation == OP_SET_COST) && hit) ||
                         ((cur_reg.operation == OP_DEL_EDGE) && hit);
                if (cur_reg.operation == OP_DEL_EDGE)
                    ram_wdata = '0;
            end
            ST_SWEEP:
            begin
                ram_we = pend_reg && edge_set;
                ram_waddr = sweep_waddr;
                ram_wdata = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        exec_ok = 1'b0;
        exec_cost = '0;
        unique case (cur_reg.operation)
            OP_ADD_VERTEX: exec_ok = x_ok && !present_reg[xs];
            OP_DEL_VERTEX: exec_ok = x_ok && present_reg[xs];
            OP_ADD_EDGE:
            begin
                exec_ok = ends && !edge_set;
                if (ends)
                    exec_cost = edge_set ? cost_old : cost_st;
            end
            OP_DEL_EDGE: exec_ok = hit;
            OP_SET_COST:
            begin
                exec_ok = hit;
                if (hit)
                    exec_cost = cost_st;
            end
            OP_LOOKUP:
            begin
                exec_ok = hit;
                if (hit)
                    exec_cost = cost_old;
            end
            default: ;
        endcase
    end

    dges_ram #(.WIDTH(MW), .DEPTH(NE)) u_edges (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign rsp_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && rsp_free;
    assign accept = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == EW'(NE - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = ((cur_reg.operation == OP_DEL_VERTEX) && x_ok &&
                                    present_reg[xs]) ? ST_SWEEP : ST_DONE;
            ST_SWEEP: if (!issue_reg && pend_reg) state_next = ST_DONE;
            ST_DONE:  if (rsp_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cur_reg <= '0;
            present_reg <= '0;
            for (int i = 0; i < NV; i++)
            begin
                in_deg_reg[i] <= '0;
                out_deg_reg[i] <= '0;
            end
            vcount_reg <= '0;
            ecount_reg <= '0;
            clr_reg <= '0;
            sj_reg <= '0;
            pj_reg <= '0;
            scol_reg <= 1'b0;
            pcol_reg <= 1'b0;
            issue_reg <= 1'b0;
            pend_reg <= 1'b0;
            ok_reg <= 1'b0;
            cost_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (out_valid_reg && rsp.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        cur_reg <= req.data;
                    end
                end
                ST_READ:
                begin
                end
                ST_EXEC:
                begin
                    ok_reg <= exec_ok;
                    cost_reg <= exec_cost;
                    if (exec_ok)
                    begin
                        unique case (cur_reg.operation)
                            OP_ADD_VERTEX:
                            begin
                                present_reg[xs] <= 1'b1;
                                vcount_reg <= vcount_reg + 1'b1;
                            end
                            OP_DEL_VERTEX:
                            begin
                                present_reg[xs] <= 1'b0;
                                in_deg_reg[xs] <= '0;
                                out_deg_reg[xs] <= '0;
                                vcount_reg <= vcount_reg - 1'b1;
                                sj_reg <= '0;
                                scol_reg <= 1'b0;
                                issue_reg <= 1'b1;
                                pend_reg <= 1'b0;
                            end
                            OP_ADD_EDGE:
                            begin
                                out_deg_reg[xs] <= out_deg_reg[xs] + 1'b1;
                                in_deg_reg[ys] <= in_deg_reg[ys] + 1'b1;
                                ecount_reg <= ecount_reg + 1'b1;
                            end
                            OP_DEL_EDGE:
                            begin
                                out_deg_reg[xs] <= out_deg_reg[xs] - 1'b1;
                                in_deg_reg[ys] <= in_deg_reg[ys] - 1'b1;
                                ecount_reg <= ecount_reg - 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    if (issue_reg)
                    begin
                        pend_reg <= 1'b1;
                        pj_reg <= sj_reg;
                        pcol_reg <= scol_reg;
                        if (sj_reg == VW'(NV - 1))
                        begin
                            sj_reg <= '0;
                            if (scol_reg)
                                issue_reg <= 1'b0;
                            else
                                scol_reg <= 1'b1;
                        end
                        else
                        begin
                            sj_reg <= sj_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && edge_set)
                    begin
                        ecount_reg <= ecount_reg - 1'b1;
                        if (pj_reg != xs)
                        begin
                            if (pcol_reg)
                                out_deg_reg[pj_reg] <= out_deg_reg[pj_reg] - 1'b1;
                            else
                                in_deg_reg[pj_reg] <= in_deg_reg[pj_reg] - 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (rsp_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.ok <= ok_reg;
                        out_reg.cost_out <=
                            IO_COST_WIDTH'({{64{cost_reg[COST_WIDTH-1]}}, cost_reg});
                        out_reg.src_present <= x_ok && present_reg[xs];
                        out_reg.src_in_degree <= x_ok ? DEG_WIDTH'(in_deg_reg[xs]) : '0;
                        out_reg.src_out_degree <= x_ok ? DEG_WIDTH'(out_deg_reg[xs]) : '0;
                        out_reg.total_vertices <= DEG_WIDTH'(vcount_reg);
                        out_reg.total_edges <= EDGES_WIDTH'(ecount_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(vcount_reg) <= NV) else $error("vertex count exceeds slots");
    a_sweep_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SWEEP) |-> !pend_reg) else $error("sweep entry pending outside sweep");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == ST_IDLE)) else $error("ready outside idle");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_IDLE)) else $error("result held outside idle");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
        else $error("result changed while waiting");
endmodule

// ===== src/dges_ram.sv =====
// Generic simple dual-port synchronous RAM with one write port and a registered read port.
module dges_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== tb/tb_directed_graph_edge_store_core.sv =====
// Randomized self-checking testbench for the directed graph edge store core.
`timescale 1ns / 100ps

module tb_directed_graph_edge_store_core;
    import dges_pkg::*;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 430;
    localparam int CALM_ITEMS = 80;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 300;
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    logic clk;
    logic rst_n;

    dges_stream_if #(.payload_t(req_t)) req (.clk(clk));
    dges_stream_if #(.payload_t(rsp_t)) rsp (.clk(clk));

    directed_graph_edge_store_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    bit         present_m [NSLOT];
    bit         linked_m [NSLOT][NSLOT];
    logic [31:0] weight_m [NSLOT][NSLOT];
    int         indeg_m [NSLOT];
    int         outdeg_m [NSLOT];
    int         nverts_m;
    int         nedges_m;

    req_t pending_ops [$];
    rsp_t expected_rsp [$];
    int   error_count;
    int   sent_count;
    int   seen_count;
    int   cycle_count;
    int   ops_seen [8];
    bit   stim_done;
    int   send_gap;
    int   recv_gap;
    int   hold_count;
    bit   hold_active;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch on result %0d: %s got %0h expected %0h",
                     seen_count, what, got, want);
            error_count++;
        end
    endtask

    function automatic void queue_op(input req_t r);
        pending_ops = {pending_ops, r};
    endfunction

    function automatic bit is_calm();
        return pending_ops.size() < CALM_ITEMS;
    endfunction

    function automatic rsp_t apply_graph_op(input req_t r);
        rsp_t o;
        int x;
        int y;
        bit ends;
        begin
            x = r.src_vertex;
            y = r.dst_vertex;
            o = '0;
            ends = present_m[x] && present_m[y];
            case (r.operation)
                OP_ADD_VERTEX:
                    if (!present_m[x])
                    begin
                        present_m[x] = 1;
                        nverts_m++;
                        o.ok = 1;
                    end
                OP_DEL_VERTEX:
                    if (present_m[x])
                    begin
                        for (int j = 0; j < NSLOT; j++)
                        begin
                            if (linked_m[x][j])
                            begin
                                linked_m[x][j] = 0;
                                indeg_m[j]--;
                                nedges_m--;
                            end
                            if (linked_m[j][x])
                            begin
                                linked_m[j][x] = 0;
                                outdeg_m[j]--;
                                nedges_m--;
                            end
                        end
                        indeg_m[x] = 0;
                        outdeg_m[x] = 0;
                        present_m[x] = 0;
                        nverts_m--;
                        o.ok = 1;
                    end
                OP_ADD_EDGE:
                    if (ends && !linked_m[x][y])
                    begin
                        linked_m[x][y] = 1;
                        weight_m[x][y] = r.edge_cost;
                        outdeg_m[x]++;
                        indeg_m[y]++;
                        nedges_m++;
                        o.ok = 1;
                    end
                OP_DEL_EDGE:
                    if (ends && linked_m[x][y])
                    begin
                        linked_m[x][y] = 0;
                        outdeg_m[x]--;
                        indeg_m[y]--;
                        nedges_m--;
                        o.ok = 1;
                    end
                OP_SET_COST:
                    if (ends && linked_m[x][y])
                    begin
                        weight_m[x][y] = r.edge_cost;
                        o.ok = 1;
                    end
                OP_LOOKUP:
                    o.ok = ends && linked_m[x][y];
                default: ;
            endcase
            if (r.operation inside {OP_ADD_EDGE, OP_DEL_EDGE, OP_SET_COST, OP_LOOKUP}
                && ends && linked_m[x][y])
                o.cost_out = weight_m[x][y];
            o.src_present = present_m[x];
            o.src_in_degree = DEG_WIDTH'(indeg_m[x]);
            o.src_out_degree = DEG_WIDTH'(outdeg_m[x]);
            o.total_vertices = DEG_WIDTH'(nverts_m);
            o.total_edges = EDGES_WIDTH'(nedges_m);
            return o;
        end
    endfunction

    function automatic req_t make_op(input logic [2:0] op, input int x, input int y,
                                     input logic [31:0] c);
        req_t r;
        begin
            r.operation = op;
            r.src_vertex = SLOT_WIDTH'(x);
            r.dst_vertex = SLOT_WIDTH'(y);
            r.edge_cost = c;
            return r;
        end
    endfunction

    function automatic logic [31:0] rand_cost();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        int x;
        int y;
        int kind;
        for (int i = 0; i < NSLOT; i++)
        begin
            present_m[i] = 0;
            indeg_m[i] = 0;
            outdeg_m[i] = 0;
            for (int j = 0; j < NSLOT; j++)
            begin
                linked_m[i][j] = 0;
                weight_m[i][j] = '0;
            end
        end
        nverts_m = 0;
        nedges_m = 0;
        error_count = 0;
        stim_done = 0;

        queue_op(make_op(OP_LOOKUP, 0, 0, 0));
        queue_op(make_op(OP_DEL_VERTEX, 0, 0, 0));
        queue_op(make_op(OP_ADD_VERTEX, 0, 5, 0));
        queue_op(make_op(OP_ADD_VERTEX, 0, 0, 0));
        queue_op(make_op(OP_ADD_VERTEX, 15, 0, 0));
        queue_op(make_op(OP_ADD_EDGE, 0, 7, 32'h1234));
        queue_op(make_op(OP_ADD_EDGE, 0, 15, 32'h8000_0000));
        queue_op(make_op(OP_ADD_EDGE, 0, 15, 32'h7fff_ffff));
        queue_op(make_op(OP_ADD_EDGE, 15, 0, 32'h7fff_ffff));
        queue_op(make_op(OP_ADD_EDGE, 15, 15, 32'hffff_ffff));
        queue_op(make_op(OP_LOOKUP, 0, 15, 0));
        queue_op(make_op(OP_SET_COST, 0, 15, 32'h5a5a_a5a5));
        queue_op(make_op(OP_SET_COST, 0, 0, 32'h1));
        queue_op(make_op(OP_DEL_EDGE, 15, 0, 0));
        queue_op(make_op(OP_DEL_EDGE, 15, 0, 0));
        queue_op(make_op(OP_UNDEF_LO, 15, 15, 32'hffff_ffff));
        queue_op(make_op(OP_UNDEF_HI, 0, 0, 0));
        queue_op(make_op(OP_DEL_VERTEX, 15, 0, 0));
        queue_op(make_op(OP_LOOKUP, 0, 15, 0));
        queue_op(make_op(OP_DEL_VERTEX, 0, 0, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                for (int v = 0; v < NSLOT; v++)
                    queue_op(make_op(OP_ADD_VERTEX, v, $urandom_range(0, 15), 0));
            x = $urandom_range(0, 15);
            y = $urandom_range(0, 15);
            kind = $urandom_range(0, 99);
            if (kind < 8)
                queue_op(make_op(OP_ADD_VERTEX, x, y, $urandom()));
            else if (kind < 14)
                queue_op(make_op(OP_DEL_VERTEX, x, y, $urandom()));
            else if (kind < 50)
                queue_op(make_op(OP_ADD_EDGE, x, y, rand_cost()));
            else if (kind < 65)
                queue_op(make_op(OP_DEL_EDGE, x, y, $urandom()));
            else if (kind < 78)
                queue_op(make_op(OP_SET_COST, x, y, rand_cost()));
            else if (kind < 96)
                queue_op(make_op(OP_LOOKUP, x, y, $urandom()));
            else
                queue_op(make_op(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), x, y,
                                 $urandom()));
        end
        stim_done = 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 0;
            req.data <= '0;
            send_gap <= 0;
            sent_count <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_rsp = {expected_rsp, apply_graph_op(req.data)};
                ops_seen[req.data.operation]++;
                sent_count <= sent_count + 1;
            end
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req.valid <= 0;
                end
                else if (pending_ops.size() > 0)
                begin
                    req.valid <= 1;
                    req.data <= pending_ops.pop_front();
                    if (!is_calm() && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 15);
                end
                else
                    req.valid <= 0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_active <= 0;
        end
        else if (!hold_active && hold_count == 0 && sent_count >= HOLD_AT)
        begin
            hold_active <= 1;
            hold_count <= 1;
        end
        else if (hold_active)
        begin
            if (hold_count == HOLD_CYCLES)
                hold_active <= 0;
            else
                hold_count <= hold_count + 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 0;
            recv_gap <= 0;
            seen_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    report_mismatch("unexpected transfer", 32'(rsp.data.ok), 32'h0);
                end
                else
                begin
                    rsp_t w;
                    w = expected_rsp.pop_front();
                    if (rsp.data.ok !== w.ok)
                        report_mismatch("ok", 32'(rsp.data.ok), 32'(w.ok));
                    if (rsp.data.cost_out !== w.cost_out)
                        report_mismatch("cost_out", rsp.data.cost_out, w.cost_out);
                    if (rsp.data.src_present !== w.src_present)
                        report_mismatch("src_present", 32'(rsp.data.src_present),
                                        32'(w.src_present));
                    if (rsp.data.src_in_degree !== w.src_in_degree)
                        report_mismatch("src_in_degree", 32'(rsp.data.src_in_degree),
                                        32'(w.src_in_degree));
                    if (rsp.data.src_out_degree !== w.src_out_degree)
                        report_mismatch("src_out_degree", 32'(rsp.data.src_out_degree),
                                        32'(w.src_out_degree));
                    if (rsp.data.total_vertices !== w.total_vertices)
                        report_mismatch("total_vertices", 32'(rsp.data.total_vertices),
                                        32'(w.total_vertices));
                    if (rsp.data.total_edges !== w.total_edges)
                        report_mismatch("total_edges", 32'(rsp.data.total_edges),
                                        32'(w.total_edges));
                end
                seen_count <= seen_count + 1;
            end
            if (hold_active)
                rsp.ready <= 0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp.ready <= 0;
            end
            else
            begin
                rsp.ready <= 1;
                if (!is_calm() && $urandom_range(0, 6) == 0)
                    recv_gap <= $urandom_range(1, 15);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (stim_done && pending_ops.size() == 0 && !req.valid && expected_rsp.size() == 0);
        repeat (100) @(posedge clk);
        if (expected_rsp.size() != 0)
            error_count++;
        $display("covered %0d requests: add/del vertex %0d/%0d, add/del edge %0d/%0d",
                 sent_count, ops_seen[OP_ADD_VERTEX], ops_seen[OP_DEL_VERTEX],
                 ops_seen[OP_ADD_EDGE], ops_seen[OP_DEL_EDGE]);
        $display("set cost %0d, lookup %0d, undefined codes %0d, %0d results checked",
                 ops_seen[OP_SET_COST], ops_seen[OP_LOOKUP],
                 ops_seen[OP_UNDEF_LO] + ops_seen[OP_UNDEF_HI], seen_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
src/dges_pkg.sv
src/dges_stream_if.sv
src/dges_ram.sv
src/directed_graph_edge_store_core.sv
tb/tb_directed_graph_edge_store_core.sv
